// ----- rtl/core/rc4_pkg.sv -----
// shared constants, codes and control types of the rc4 byte-stream cipher
// used by the controller, datapath and top level; depends on nothing
`timescale 1ns / 1ps

package rc4_pkg;

   // permutation table geometry (fixed by the cipher)
   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = 8;

   // key store geometry
   localparam int KEY_DEPTH = 256;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   // key length register
   localparam int          LEN_W         = 9;
   localparam logic [8:0]  KEY_LEN_RESET = 9'd16;

   // request kinds carried in tuser
   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_START = 2'd1,
      OP_DATA  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_READ,
      ST_KS_SUM,
      ST_KS_WR_K,
      ST_KS_WR_J,
      ST_DT_READ_I,
      ST_DT_READ_J,
      ST_DT_WR_I,
      ST_DT_WR_J,
      ST_DT_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture the accepted data byte
      logic key_wr;    // write the accepted key byte
      logic ks_clear;  // clear k, j and key position
      logic fill_wr;   // write S[k] = k, advance k
      logic ks_rd_k;   // read S[k] and key[pos]
      logic ks_sum;    // j += S[k] + key[pos], read S[j]
      logic ks_wr_k;   // write S[k] = S[j]
      logic ks_wr_j;   // write S[j] = old S[k], advance k and pos
      logic dt_rd_i;   // i += 1, read S[i]
      logic dt_rd_j;   // j += S[i], read S[j]
      logic dt_wr_i;   // write S[i] = S[j]
      logic dt_wr_j;   // write S[j] = old S[i], read S[S[i] + S[j]]
      logic dt_out;    // load the result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic k_last;    // schedule counter at its last entry
      logic out_free;  // result register can take a new byte
   } status_type;

endpackage

// ----- rtl/core/rc4_stream_cipher.sv -----
// RC4 byte-stream cipher. A request transaction carries a kind in tuser: a key
// byte (written to the key store at key_index), a start (runs the key schedule:
// loads the identity permutation, then does the 256 keyed swaps, each a read,
// a sum and the writes of S[k] and S[j]) or a data byte, answered by one
// response transaction holding the byte XORed with the next keystream byte once
// the result register is free. An unused kind is dropped. All timing is set by
// the permutation memory: every read and every swap write goes through its one
// read and one write port in turn. Data bytes are valid only after a start. The user
// must write the key length register only while the block is idle; the block does not enforce it.
// top level; depends on rc4_pkg, rc4_ctrl, rc4_datapath and rc4_ram
`timescale 1ns / 1ps

module rc4_stream_cipher
   import rc4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key_index, [15:8] in_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   // key length register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   op_type     req_op;

   assign req_op    = op_type'(req_tuser);
   assign csr_ready = 1'b1;

   rc4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rc4_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .key_index  (req_tdata[7:0]),
      .in_byte    (req_tdata[15:8]),
      .csr_write  (csr_valid && csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // a start or data transaction keeps the block busy afterwards
   a_busy_after_work : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && ((req_op == OP_START) || (req_op == OP_DATA)))
      |=> !req_tready)
      else $error("block ready right after a start or data transaction");

   // after a key byte or unused kind the block is ready again in the next cycle
   a_key_one_cycle : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && ((req_op == OP_KEY) || (req_op == OP_NONE)))
      |=> req_tready)
      else $error("block busy after a key byte transaction");

   // a new result appears as the controller returns to idle
   a_result_at_idle : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded while the controller is still busy");

   // a result is loaded only after the five-step keystream sequence
   a_result_latency : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready, 1))
      else $error("result loaded without a keystream step");
`endif

endmodule

// ----- rtl/core/rc4_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies; read returns the stored value before a same-cycle write
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rc4_datapath.sv -----
// rc4 datapath: permutation and key memories, indices, key length and result register
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps

module rc4_datapath
   import rc4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [7:0]       key_index,
   input  logic [7:0]       in_byte,
   input  logic             csr_write,
   input  logic [LEN_W-1:0] csr_wdata,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [7:0]       rsp_tdata
);

   logic [LEN_W-1:0]   key_len_ff, key_len_in;
   logic [LEN_W-1:0]   eff_len;
   logic [PERM_AW-1:0] k_ff, k_in;
   logic [KEY_AW-1:0]  pos_ff, pos_in;
   logic [PERM_AW-1:0] i_ff, i_in;
   logic [PERM_AW-1:0] j_ff, j_in;
   logic [7:0]         s_a_ff, s_a_in;
   logic [7:0]         s_b_ff, s_b_in;
   logic               hit_ff, hit_in;
   logic [7:0]         byte_ff, byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;

   logic               perm_wr_en;
   logic [PERM_AW-1:0] perm_wr_addr;
   logic [7:0]         perm_wr_data;
   logic               perm_rd_en;
   logic [PERM_AW-1:0] perm_rd_addr;
   logic [7:0]         perm_rd_data;
   logic               key_wr_en;
   logic [7:0]         key_rd_data;
   logic [PERM_AW-1:0] t_sum;
   logic [7:0]         ks_byte;

   // effective key length, saturated to 1 .. KEY_DEPTH
   always_comb begin
      if (key_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (key_len_ff > LEN_W'(KEY_DEPTH)) begin
         eff_len = LEN_W'(KEY_DEPTH);
      end else begin
         eff_len = key_len_ff;
      end
   end

   // key bytes beyond the store are dropped
   assign key_wr_en = cmd.key_wr && ({1'b0, key_index} < 9'(KEY_DEPTH));

   assign t_sum   = s_a_ff + s_b_ff;
   assign ks_byte = hit_ff ? s_a_ff : perm_rd_data;

   // register next values
   always_comb begin
      key_len_in   = key_len_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      s_a_in       = s_a_ff;
      s_b_in       = s_b_ff;
      hit_in       = hit_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         key_len_in = csr_wdata;
      end
      if (cmd.load) begin
         byte_in = in_byte;
      end
      if (cmd.ks_clear) begin
         k_in   = '0;
         pos_in = '0;
         j_in   = '0;
      end
      if (cmd.fill_wr) begin
         k_in = k_ff + PERM_AW'(1);
      end
      if (cmd.ks_sum) begin
         s_a_in = perm_rd_data;
         j_in   = j_ff + perm_rd_data + key_rd_data;
      end
      if (cmd.ks_wr_j) begin
         k_in = k_ff + PERM_AW'(1);
         if ((LEN_W'(pos_ff) + LEN_W'(1)) == eff_len) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + KEY_AW'(1);
         end
         // schedule done: generator indices restart
         if (status.k_last) begin
            i_in = '0;
            j_in = '0;
         end
      end
      if (cmd.dt_rd_i) begin
         i_in = i_ff + PERM_AW'(1);
      end
      if (cmd.dt_rd_j) begin
         s_a_in = perm_rd_data;
         j_in   = j_ff + perm_rd_data;
      end
      if (cmd.dt_wr_i) begin
         s_b_in = perm_rd_data;
      end
      if (cmd.dt_wr_j) begin
         // the read of S[t] sees the old S[j] when t hits j
         hit_in = (t_sum == j_ff);
      end

      // result register, one transaction deep
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.dt_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = byte_ff ^ ks_byte;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff   <= KEY_LEN_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_len_ff   <= key_len_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      s_a_ff      <= s_a_in;
      s_b_ff      <= s_b_in;
      hit_ff      <= hit_in;
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // permutation memory port selection
   always_comb begin
      perm_wr_en   = 1'b1;
      perm_wr_addr = k_ff;
      perm_wr_data = k_ff;
      if (cmd.ks_wr_k) begin
         perm_wr_data = perm_rd_data;
      end else if (cmd.ks_wr_j) begin
         perm_wr_addr = j_ff;
         perm_wr_data = s_a_ff;
      end else if (cmd.dt_wr_i) begin
         perm_wr_addr = i_ff;
         perm_wr_data = perm_rd_data;
      end else if (cmd.dt_wr_j) begin
         perm_wr_addr = j_ff;
         perm_wr_data = s_a_ff;
      end else if (!cmd.fill_wr) begin
         perm_wr_en = 1'b0;
      end

      perm_rd_en   = 1'b1;
      perm_rd_addr = k_ff;
      if (cmd.ks_sum) begin
         perm_rd_addr = j_in;
      end else if (cmd.dt_rd_i) begin
         perm_rd_addr = i_in;
      end else if (cmd.dt_rd_j) begin
         perm_rd_addr = j_in;
      end else if (cmd.dt_wr_j) begin
         perm_rd_addr = t_sum;
      end else if (!cmd.ks_rd_k) begin
         perm_rd_en = 1'b0;
      end
   end

   rc4_ram #(
      .WIDTH (8),
      .DEPTH (PERM_SIZE)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_wr_en),
      .wr_addr (perm_wr_addr),
      .wr_data (perm_wr_data),
      .rd_en   (perm_rd_en),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_data)
   );

   rc4_ram #(
      .WIDTH (8),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_index[KEY_AW-1:0]),
      .wr_data (in_byte),
      .rd_en   (cmd.ks_rd_k),
      .rd_addr (pos_ff),
      .rd_data (key_rd_data)
   );

   // status and outputs
   assign status.k_last   = (k_ff == PERM_AW'(PERM_SIZE - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

// ----- rtl/core/rc4_ctrl.sv -----
// rc4 controller: sequences key writes, key schedule and keystream steps
// depends on rc4_pkg
`timescale 1ns / 1ps

module rc4_ctrl
   import rc4_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  op_type     req_op,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_START)) begin
               state_in = ST_FILL;
            end else if (accept && (req_op == OP_DATA)) begin
               state_in = ST_DT_READ_I;
            end
         end
         ST_FILL: begin
            if (status.k_last) begin
               state_in = ST_KS_READ;
            end
         end
         ST_KS_READ:   state_in = ST_KS_SUM;
         ST_KS_SUM:    state_in = ST_KS_WR_K;
         ST_KS_WR_K:   state_in = ST_KS_WR_J;
         ST_KS_WR_J: begin
            state_in = status.k_last ? ST_IDLE : ST_KS_READ;
         end
         ST_DT_READ_I: state_in = ST_DT_READ_J;
         ST_DT_READ_J: state_in = ST_DT_WR_I;
         ST_DT_WR_I:   state_in = ST_DT_WR_J;
         ST_DT_WR_J:   state_in = ST_DT_OUT;
         ST_DT_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load     = accept;
            cmd.key_wr   = accept && (req_op == OP_KEY);
            cmd.ks_clear = accept && (req_op == OP_START);
         end
         ST_FILL:      cmd.fill_wr = 1'b1;
         ST_KS_READ:   cmd.ks_rd_k = 1'b1;
         ST_KS_SUM:    cmd.ks_sum  = 1'b1;
         ST_KS_WR_K:   cmd.ks_wr_k = 1'b1;
         ST_KS_WR_J:   cmd.ks_wr_j = 1'b1;
         ST_DT_READ_I: cmd.dt_rd_i = 1'b1;
         ST_DT_READ_J: cmd.dt_rd_j = 1'b1;
         ST_DT_WR_I:   cmd.dt_wr_i = 1'b1;
         ST_DT_WR_J:   cmd.dt_wr_j = 1'b1;
         ST_DT_OUT:    cmd.dt_out  = status.out_free;
         default:      cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
